FILE: design/assert_macros.svh
// Assertion macros used by the top-level core RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, ant, cons)
`define ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

FILE: design/rmed_pkg.sv
// Types and constants of the running median block
package rmed_pkg;
  localparam int CAPACITY = 1024;
  localparam int VW = 32;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int OW = VW + 1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_CHK, S_ADD_CMP, S_REM_CHK, S_REM_CMP,
    S_SH_CHK, S_SH_WR, S_MED_RD, S_MED_A, S_MED_B, S_ERR
  } state_t;

  typedef enum logic [2:0] {
    RD_IDX_M1, RD_IDX, RD_IDX_P1, RD_MID_HI, RD_MID_LO
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_val;
    logic    idx_inc;
    logic    idx_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    hold_a;
    logic    fin_med;
    logic    fin_err;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic idx_at_cnt;
    logic last_shift;
    logic cnt_one;
    logic less;
    logic equal;
    logic out_busy;
  } sts_t;
endpackage

FILE: design/rmed_datapath.sv
// Sorted store, index and count registers, median adder, output register
module rmed_datapath import rmed_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  output sts_t          sts,
  input  logic          in_cmd,
  input  logic [VW-1:0] in_value,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,
  output logic [1:0]    m_tuser
);
  logic [VW-1:0] mem [CAPACITY];
  logic [VW-1:0] rdata;
  logic [VW-1:0] a;
  logic [VW-1:0] val;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic          full_r;
  logic [CW-1:0] raddr;
  logic [OW-1:0] sum;

  always_comb begin
    case (ctl.rd_sel)
      RD_IDX_M1: raddr = idx - CW'(1);
      RD_IDX:    raddr = idx;
      RD_IDX_P1: raddr = idx + CW'(1);
      RD_MID_HI: raddr = count >> 1;
      RD_MID_LO: raddr = (count - CW'(1)) >> 1;
      default:   raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr[AW-1:0]];
    end
    if (ctl.wr_en) begin
      mem[idx[AW-1:0]] <= ctl.wr_val ? val : rdata;
    end
  end

  assign sum = {a[VW-1], a} + {rdata[VW-1], rdata};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val    <= in_value;
      full_r <= !in_cmd && (count == CW'(CAPACITY));
    end
    if (ctl.hold_a) begin
      a <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= ST_OK;
    end else begin
      if (ctl.load) begin
        idx <= in_cmd ? '0 : count;
      end else if (ctl.idx_inc) begin
        idx <= idx + CW'(1);
      end else if (ctl.idx_dec) begin
        idx <= idx - CW'(1);
      end
      if (ctl.cnt_inc) begin
        count <= count + CW'(1);
      end else if (ctl.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (ctl.fin_med) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(40-OW){1'b0}}, sum};
        m_tuser  <= full_r ? ST_FULL : ST_OK;
      end else if (ctl.fin_err) begin
        m_tvalid <= 1'b1;
        m_tdata  <= '0;
        m_tuser  <= ST_ERR;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.full       = full_r;
    sts.idx_zero   = (idx == '0);
    sts.idx_at_cnt = (idx == count);
    sts.last_shift = ((idx + CW'(1)) == count);
    sts.cnt_one    = (count == CW'(1));
    sts.less       = $signed(val) < $signed(rdata);
    sts.equal      = (val == rdata);
    sts.out_busy   = m_tvalid && !m_tready;
  end
endmodule

FILE: design/rmed_ctrl.sv
// Request sequencer: insert, search, shift and median read steps
module rmed_ctrl import rmed_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic in_cmd,
  output logic s_tready,
  input  sts_t sts,
  output ctl_t ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rd_sel = RD_IDX;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = in_cmd ? S_REM_CHK : S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        if (sts.full) begin
          state_next = S_MED_RD;
        end else if (sts.idx_zero) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_val  = 1'b1;
          ctl.cnt_inc = 1'b1;
          state_next  = S_MED_RD;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_M1;
          state_next = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        ctl.wr_en = 1'b1;
        if (sts.less) begin
          ctl.idx_dec = 1'b1;
          state_next  = S_ADD_CHK;
        end else begin
          ctl.wr_val  = 1'b1;
          ctl.cnt_inc = 1'b1;
          state_next  = S_MED_RD;
        end
      end
      S_REM_CHK: begin
        if (sts.idx_at_cnt) begin
          state_next = S_ERR;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (sts.equal) begin
          state_next = S_SH_CHK;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_REM_CHK;
        end
      end
      S_SH_CHK: begin
        if (sts.last_shift) begin
          ctl.cnt_dec = 1'b1;
          state_next  = sts.cnt_one ? S_ERR : S_MED_RD;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_P1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.idx_inc = 1'b1;
        state_next  = S_SH_CHK;
      end
      S_MED_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_MID_HI;
        state_next = S_MED_A;
      end
      S_MED_A: begin
        ctl.hold_a = 1'b1;
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_MID_LO;
        state_next = S_MED_B;
      end
      S_MED_B: begin
        if (!sts.out_busy) begin
          ctl.fin_med = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_ERR: begin
        if (!sts.out_busy) begin
          ctl.fin_err = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: design/running_median_insert_delete_core.sv
// Running median over a sorted store with add and remove requests.
// An add compares from the top entry down, moving each larger entry up, then
// writes the value; a full store skips the write. A remove searches up from
// entry 0, then shifts the later entries down. Both end with reads of the two
// middle entries; an absent value or a remove that empties the store gives an
// error beat instead. Only one request is in flight at a time.
// Synchronous reset empties the store (count to zero); no clearing pass.
// Result beat is registered; a new request is taken while it waits.
`include "assert_macros.svh"
module running_median_insert_delete_core import rmed_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,  // operand_value[31:0]
  input  logic          s_tuser,  // command[0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,  // twice_median[32:0], zero pad
  output logic [1:0]    m_tuser   // status[1:0]
);
  ctl_t ctl;
  sts_t sts;

  rmed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_cmd   (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rmed_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .in_cmd   (s_tuser),
    .in_value (s_tdata[VW-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
  `ASSERT_SAME(a_status_code, m_tvalid, m_tuser != 2'd3)
  `ASSERT_SAME(a_err_zero, m_tvalid && (m_tuser == ST_ERR), m_tdata == '0)
  `ASSERT_SAME(a_no_double_finish, 1'b1, !(ctl.fin_med && ctl.fin_err))
endmodule
